/* rtl/rps_pkg.sv */
// ----------------------------------------------------------------------------
// rps_pkg: shared types and constants of the reflow profile sequencer
// Phase, command and register index codes, the configuration record, the
// controller/datapath command and status structs and the setpoint clamp.
// ----------------------------------------------------------------------------
package rps_pkg;

    // Run phases
    localparam logic [2:0] PH_OFF      = 3'd0;
    localparam logic [2:0] PH_PREHEAT  = 3'd1;
    localparam logic [2:0] PH_SOAK     = 3'd2;
    localparam logic [2:0] PH_RAMPUP   = 3'd3;
    localparam logic [2:0] PH_DWELL    = 3'd4;
    localparam logic [2:0] PH_RAMPDOWN = 3'd5;
    localparam logic [2:0] PH_COMPLETE = 3'd6;
    localparam logic [2:0] PH_FAIL     = 3'd7;

    // Commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_ABORT = 2'd2;
    localparam logic [1:0] CMD_OFF   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_SOAK_START = 3'd0;
    localparam logic [2:0] CFG_SOAK_END   = 3'd1;
    localparam logic [2:0] CFG_SOAK_DUR   = 3'd2;
    localparam logic [2:0] CFG_PEAK       = 3'd3;
    localparam logic [2:0] CFG_DWELL_DUR  = 3'd4;
    localparam logic [2:0] CFG_PRE_SLOPE  = 3'd5;
    localparam logic [2:0] CFG_RAMP_SLOPE = 3'd6;
    localparam logic [2:0] CFG_COOL_SLOPE = 3'd7;

    // Register reset values
    localparam logic [8:0]        RST_SOAK_START = 9'd150;
    localparam logic [8:0]        RST_SOAK_END   = 9'd200;
    localparam logic [9:0]        RST_SOAK_DUR   = 10'd90;
    localparam logic [8:0]        RST_PEAK       = 9'd245;
    localparam logic [9:0]        RST_DWELL_DUR  = 10'd30;
    localparam logic [7:0]        RST_PRE_SLOPE  = 8'd16;
    localparam logic [7:0]        RST_RAMP_SLOPE = 8'd16;
    localparam logic signed [8:0] RST_COOL_SLOPE = -9'sd32;

    // Setpoint range and stall limits
    localparam logic signed [13:0] SP_MIN = -14'sd4096;
    localparam logic signed [13:0] SP_MAX = 14'sd8191;
    localparam logic [5:0] PREHEAT_STALL_LIMIT = 6'd20;
    localparam logic [5:0] LATE_STALL_LIMIT    = 6'd40;
    localparam logic [5:0] STALL_MAX           = 6'd63;

    typedef struct packed {
        logic [8:0]        soak_start_temp;
        logic [8:0]        soak_end_temp;
        logic [9:0]        soak_duration;
        logic [8:0]        peak_temp;
        logic [9:0]        dwell_duration;
        logic [7:0]        preheat_slope;
        logic [7:0]        rampup_slope;
        logic signed [8:0] cooldown_slope;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the accepted item
        logic mul;       // form the interpolation product, seed the divider
        logic div_step;  // one quotient bit
        logic commit;    // update run state and the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_div;  // latched item is a tick during soak
    } t_dp_sts;

    // Clamp a 16-bit signed sum into the setpoint range
    function automatic logic signed [13:0] clamp_sp(input logic signed [15:0] v);
        logic signed [13:0] r;
        if (v < 16'(SP_MIN)) begin
            r = SP_MIN;
        end else if (v > 16'(SP_MAX)) begin
            r = SP_MAX;
        end else begin
            r = v[13:0];
        end
        return r;
    endfunction

endpackage

/* rtl/rps_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rps_cfg_regs: profile configuration registers
// Eight write-only registers loaded over the configuration channel.
// ----------------------------------------------------------------------------
module rps_cfg_regs
    import rps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [9:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.soak_start_temp <= RST_SOAK_START;
            r_cfg.soak_end_temp   <= RST_SOAK_END;
            r_cfg.soak_duration   <= RST_SOAK_DUR;
            r_cfg.peak_temp       <= RST_PEAK;
            r_cfg.dwell_duration  <= RST_DWELL_DUR;
            r_cfg.preheat_slope   <= RST_PRE_SLOPE;
            r_cfg.rampup_slope    <= RST_RAMP_SLOPE;
            r_cfg.cooldown_slope  <= RST_COOL_SLOPE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SOAK_START: r_cfg.soak_start_temp <= i_cfg_data[8:0];
                CFG_SOAK_END:   r_cfg.soak_end_temp   <= i_cfg_data[8:0];
                CFG_SOAK_DUR:   r_cfg.soak_duration   <= i_cfg_data;
                CFG_PEAK:       r_cfg.peak_temp       <= i_cfg_data[8:0];
                CFG_DWELL_DUR:  r_cfg.dwell_duration  <= i_cfg_data;
                CFG_PRE_SLOPE:  r_cfg.preheat_slope   <= i_cfg_data[7:0];
                CFG_RAMP_SLOPE: r_cfg.rampup_slope    <= i_cfg_data[7:0];
                CFG_COOL_SLOPE: r_cfg.cooldown_slope  <= $signed(i_cfg_data[8:0]);
                default: ;
            endcase
        end
    end

endmodule

/* rtl/rps_ctrl.sv */
// ----------------------------------------------------------------------------
// rps_ctrl: sequencing controller
// Accepts an item, runs the soak divider when needed, commits the result
// into the output register and owns the output valid flag.
// ----------------------------------------------------------------------------
module rps_ctrl
    import rps_pkg::*;
#(
    parameter int DIV_STEPS = 25
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam int CNTW = $clog2(DIV_STEPS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    logic [2:0]      r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = i_sts.need_div ? ST_MUL : ST_COMMIT;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = CNTW'(DIV_STEPS - 1);
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_COMMIT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_COMMIT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/rps_datapath.sv */
// ----------------------------------------------------------------------------
// rps_datapath: run state, soak interpolation and result register
// Holds the run state, the latched item, a restoring divider for the soak
// interpolation and the output payload register.
// ----------------------------------------------------------------------------
module rps_datapath
    import rps_pkg::*;
#(
    parameter int FRAC_BITS  = 4,
    parameter int TICK_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [1:0]         i_command,
    input  logic signed [13:0] i_measured_temp,
    output logic [2:0]         o_phase,
    output logic signed [13:0] o_setpoint_out,
    output logic               o_shutdown,
    output logic [15:0]        o_elapsed_seconds
);

    localparam int TW = TICK_WIDTH;
    localparam int QW = TICK_WIDTH + 9;              // product / quotient width
    localparam int DW = QW + 2;                      // signed degrees
    localparam int FW = DW + FRAC_BITS;              // signed fixed point
    localparam int CW = (FRAC_BITS + 10 > 15) ? FRAC_BITS + 10 : 15;
    localparam int EW = (TW > 16) ? TW : 16;
    localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

    // Run state
    logic [2:0]         r_phase, n_phase;
    logic [TW-1:0]      r_tick, n_tick;
    logic signed [13:0] r_tgt, n_tgt;
    logic signed [13:0] r_amb, n_amb;
    logic [TW-1:0]      r_soak_begin, n_soak_begin;
    logic [TW-1:0]      r_dwell_begin, n_dwell_begin;
    logic [5:0]         r_stall, n_stall;

    // Latched item
    logic [1:0]         r_cmd;
    logic signed [13:0] r_meas;

    // Divider
    logic [QW-1:0] r_quo;
    logic [9:0]    r_rem;
    logic          r_neg;

    // Output payload
    logic [2:0]         r_o_phase;
    logic signed [13:0] r_o_sp;
    logic               r_o_shut;
    logic [15:0]        r_o_elapsed;

    assign o_sts.need_div = (r_cmd == CMD_TICK) && (r_phase == PH_SOAK);

    // Thresholds in fixed point
    logic signed [CW-1:0] ss_fx, se_fx, pk_fx, tgt_w, meas_w;
    assign ss_fx  = $signed(CW'(i_cfg.soak_start_temp) << FRAC_BITS);
    assign se_fx  = $signed(CW'(i_cfg.soak_end_temp) << FRAC_BITS);
    assign pk_fx  = $signed(CW'(i_cfg.peak_temp) << FRAC_BITS);
    assign tgt_w  = CW'(r_tgt);
    assign meas_w = CW'(r_meas);

    // Saturating elapsed count
    logic [TW-1:0] tick_inc;
    assign tick_inc = (r_tick < TICK_MAX) ? r_tick + 1'b1 : r_tick;

    // Interpolation product operands
    logic [TW-1:0]     dt;
    logic signed [9:0] diff;
    logic [8:0]        absdiff;
    logic [9:0]        divisor;
    assign dt      = tick_inc - r_soak_begin;
    assign diff    = $signed({1'b0, i_cfg.soak_end_temp})
                   - $signed({1'b0, i_cfg.soak_start_temp});
    assign absdiff = diff[9] ? 9'(-diff) : diff[8:0];
    assign divisor = (i_cfg.soak_duration == '0) ? 10'd1 : i_cfg.soak_duration;

    // Restoring divider step
    logic [10:0] rem_sh;
    logic        q_bit;
    assign rem_sh = {r_rem, r_quo[QW-1]};
    assign q_bit  = (rem_sh >= {1'b0, divisor});

    // Interpolated setpoint
    logic signed [DW-1:0] q_s, deg;
    logic signed [FW-1:0] fixed;
    logic signed [13:0]   interp_tgt;
    assign q_s   = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
    assign deg   = q_s + $signed(DW'({1'b0, i_cfg.soak_start_temp}));
    assign fixed = $signed(FW'(deg)) <<< FRAC_BITS;
    always_comb begin
        if (fixed < FW'(SP_MIN)) begin
            interp_tgt = SP_MIN;
        end else if (fixed > FW'(SP_MAX)) begin
            interp_tgt = SP_MAX;
        end else begin
            interp_tgt = fixed[13:0];
        end
    end

    // Slope steps
    logic signed [13:0] pre_tgt, ramp_tgt, cool_tgt;
    assign pre_tgt  = clamp_sp(16'(r_tgt) + $signed({8'd0, i_cfg.preheat_slope}));
    assign ramp_tgt = clamp_sp(16'(r_tgt) + $signed({8'd0, i_cfg.rampup_slope}));
    assign cool_tgt = clamp_sp(16'(r_tgt) + 16'(i_cfg.cooldown_slope));

    // Time limits
    logic soak_time_up, dwell_time_up;
    assign soak_time_up  = ({1'b0, tick_inc}
                         >= (TW+1)'(r_soak_begin) + (TW+1)'(i_cfg.soak_duration));
    assign dwell_time_up = ({1'b0, tick_inc}
                         > (TW+1)'(r_dwell_begin) + (TW+1)'(i_cfg.dwell_duration));

    // Run state update for the latched item
    logic [5:0] stall_base, stall_inc;
    always_comb begin
        n_phase       = r_phase;
        n_tick        = r_tick;
        n_tgt         = r_tgt;
        n_amb         = r_amb;
        n_soak_begin  = r_soak_begin;
        n_dwell_begin = r_dwell_begin;
        n_stall       = r_stall;
        stall_base    = r_stall;
        stall_inc     = (r_stall == STALL_MAX) ? r_stall : r_stall + 1'b1;
        case (r_cmd)
            CMD_TICK: begin
                if (r_phase != PH_OFF) begin
                    n_tick = tick_inc;
                end
                unique case (r_phase)
                    PH_PREHEAT: begin
                        if (tgt_w < ss_fx) begin
                            n_tgt   = pre_tgt;
                            n_stall = '0;
                        end else begin
                            n_stall = stall_inc;
                            if (stall_inc > PREHEAT_STALL_LIMIT) begin
                                n_phase = PH_FAIL;
                            end
                        end
                        if (meas_w >= ss_fx) begin
                            n_phase      = PH_SOAK;
                            n_soak_begin = tick_inc;
                        end
                    end
                    PH_SOAK: begin
                        if (tgt_w < se_fx) begin
                            n_tgt      = interp_tgt;
                            stall_base = '0;
                            n_stall    = '0;
                        end
                        if (soak_time_up) begin
                            if (meas_w >= se_fx) begin
                                n_phase = PH_RAMPUP;
                            end else begin
                                n_stall = (stall_base == STALL_MAX) ? stall_base
                                                                    : stall_base + 1'b1;
                                if (n_stall > LATE_STALL_LIMIT) begin
                                    n_phase = PH_FAIL;
                                end
                            end
                        end
                    end
                    PH_RAMPUP: begin
                        if (tgt_w < pk_fx) begin
                            n_tgt      = ramp_tgt;
                            stall_base = '0;
                            n_stall    = '0;
                        end
                        if (meas_w >= pk_fx) begin
                            n_phase       = PH_DWELL;
                            n_dwell_begin = tick_inc;
                        end else begin
                            n_stall = (stall_base == STALL_MAX) ? stall_base
                                                                : stall_base + 1'b1;
                            if (n_stall > LATE_STALL_LIMIT) begin
                                n_phase = PH_FAIL;
                            end
                        end
                    end
                    PH_DWELL: begin
                        if (dwell_time_up) begin
                            n_phase = PH_RAMPDOWN;
                        end
                    end
                    PH_RAMPDOWN: begin
                        if (r_tgt > r_amb) begin
                            n_tgt = cool_tgt;
                        end
                        if (r_meas < r_amb) begin
                            n_phase = PH_COMPLETE;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_START: begin
                n_phase       = PH_PREHEAT;
                n_tick        = '0;
                n_amb         = r_meas;
                n_tgt         = clamp_sp(16'(r_meas));
                n_soak_begin  = '0;
                n_dwell_begin = '0;
                n_stall       = '0;
            end
            CMD_ABORT: begin
                if (r_phase != PH_COMPLETE) begin
                    n_phase = PH_FAIL;
                end
            end
            default: begin
                n_phase = PH_OFF;
                n_tgt   = '0;
            end
        endcase
    end

    // Result fields from the next state
    logic          n_shut;
    logic [EW-1:0] tick_ext;
    assign n_shut   = (n_phase == PH_COMPLETE) || (n_phase == PH_FAIL);
    assign tick_ext = EW'(n_tick);

    // Run state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_OFF;
            r_tick        <= '0;
            r_tgt         <= '0;
            r_amb         <= '0;
            r_soak_begin  <= '0;
            r_dwell_begin <= '0;
            r_stall       <= '0;
        end else if (i_cmd.commit) begin
            r_phase       <= n_phase;
            r_tick        <= n_tick;
            r_tgt         <= n_tgt;
            r_amb         <= n_amb;
            r_soak_begin  <= n_soak_begin;
            r_dwell_begin <= n_dwell_begin;
            r_stall       <= n_stall;
        end
    end

    // Item latch, divider and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_meas <= i_measured_temp;
        end
        if (i_cmd.mul) begin
            r_quo <= QW'(dt) * QW'(absdiff);
            r_rem <= '0;
            r_neg <= diff[9];
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[QW-2:0], q_bit};
            r_rem <= q_bit ? 10'(rem_sh - {1'b0, divisor}) : rem_sh[9:0];
        end
        if (i_cmd.commit) begin
            r_o_phase   <= n_phase;
            r_o_sp      <= n_shut ? 14'sd0 : n_tgt;
            r_o_shut    <= n_shut;
            r_o_elapsed <= (tick_ext > EW'(16'hFFFF)) ? 16'hFFFF : tick_ext[15:0];
        end
    end

    assign o_phase           = r_o_phase;
    assign o_setpoint_out    = r_o_sp;
    assign o_shutdown        = r_o_shut;
    assign o_elapsed_seconds = r_o_elapsed;

endmodule

/* rtl/reflow_profile_sequencer_top.sv */
// ----------------------------------------------------------------------------
// reflow_profile_sequencer_top: reflow oven setpoint sequencer
// Controller, datapath and configuration registers of the sequencer.
// ----------------------------------------------------------------------------
// Each input transfer carries a command (tick, start, abort, return to off)
// and the measured oven temperature, and yields exactly one result transfer
// with phase, setpoint, shutdown flag and elapsed seconds. A tick during soak
// passes from acceptance through evaluation, the interpolation product and the
// bit-serial restoring divider, which forms the soak interpolation one quotient
// bit per cycle, to the commit; every other item goes from evaluation straight
// to the commit. The input is ready again the cycle after the result is
// committed. A result still waiting in the output register holds the commit of
// the next one until the receiver takes it.
// One item is in work at a time; a new item is accepted while the previous
// result still waits in the output register. Configuration writes are taken
// at any time but are meant for idle periods only.
module reflow_profile_sequencer_top
    import rps_pkg::*;
#(
    parameter int FRAC_BITS  = 4,
    parameter int TICK_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_command,
    input  logic signed [13:0] i_measured_temp,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_phase,
    output logic signed [13:0] o_setpoint_out,
    output logic               o_shutdown,
    output logic [15:0]        o_elapsed_seconds,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data
);

    t_cfg    cfg;
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rps_ctrl #(
        .DIV_STEPS (TICK_WIDTH + 9)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    rps_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_cmd             (dp_cmd),
        .o_sts             (dp_sts),
        .i_command         (i_command),
        .i_measured_temp   (i_measured_temp),
        .o_phase           (o_phase),
        .o_setpoint_out    (o_setpoint_out),
        .o_shutdown        (o_shutdown),
        .o_elapsed_seconds (o_elapsed_seconds)
    );

endmodule
